// ===== hdl/serial_phrase_trigger_responder_macros.svh =====
// Assertion macros used by the file that carries concurrent checks.
`ifndef SERIAL_PHRASE_TRIGGER_RESPONDER_MACROS_SVH
`define SERIAL_PHRASE_TRIGGER_RESPONDER_MACROS_SVH

// Same-cycle implication, sampled on clk and off while rst is high.
`define SPT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spt assertion failed");

// Next-cycle implication, sampled on clk and off while rst is high.
`define SPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spt assertion failed");

`endif

// ===== hdl/spt_pkg.sv =====
package spt_pkg;

  localparam int unsigned PHRASE_CHARS = 45;
  localparam logic [8*PHRASE_CHARS-1:0] PHRASE_STR =
    "Use the ^ and v keys to change the selection.";

  localparam logic [7:0] KEY_DOWN  = 8'h76;
  localparam logic [7:0] KEY_ENTER = 8'h0D;

  localparam logic [15:0] BIT_TICKS_RESET = 16'd104;

  // Register index, taken from paddr[2].
  localparam logic REG_BIT_TICKS = 1'b0;

  typedef struct packed {
    logic       tx_level;
    logic       byte_done;
    logic [7:0] rx_byte;
    logic       phrase_hit;
  } spt_result_t;

  // Character at a position of the phrase, oldest first; zero past its end.
  function automatic logic [7:0] phrase_char(input int unsigned idx);
    if (idx < PHRASE_CHARS) begin
      return PHRASE_STR[8*(PHRASE_CHARS-1-idx) +: 8];
    end else begin
      return 8'h00;
    end
  endfunction

endpackage

// ===== hdl/spt_cell.sv =====
module spt_cell (
  input  logic       clk,
  input  logic       rst,
  input  logic       shift_en,
  input  logic [7:0] din,
  input  logic [7:0] cmp,
  output logic [7:0] dout,
  output logic       eq
);

  // eq tells whether the held byte matches the phrase character of the
  // position that this byte moves into on the next shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= 8'h00;
      eq   <= (cmp == 8'h00);
    end else if (shift_en) begin
      dout <= din;
      eq   <= (din == cmp);
    end
  end

endmodule

// ===== hdl/spt_window.sv =====
module spt_window #(
  parameter int unsigned LEN = 45
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       shift_en,
  input  logic [7:0] new_byte,
  output logic       hit
);
  import spt_pkg::*;

  logic [7:0] cell_byte [LEN];
  logic [LEN-1:0] cell_eq;

  for (genvar i = 0; i < LEN; i++) begin : g_cell
    logic [7:0] din;
    if (i == LEN - 1) begin : g_last
      assign din = new_byte;
    end else begin : g_mid
      assign din = cell_byte[i+1];
    end
    spt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift_en (shift_en),
      .din      (din),
      .cmp      (phrase_char((i == 0) ? 0 : i - 1)),
      .dout     (cell_byte[i]),
      .eq       (cell_eq[i])
    );
  end

  // The window after the push matches if every held byte but the oldest
  // matches one place further along and the arriving byte matches the end.
  logic tail_ok;
  logic rest_ok;
  assign tail_ok = (new_byte == phrase_char(LEN - 1));

  if (LEN > 1) begin : g_rest
    assign rest_ok = &cell_eq[LEN-1:1];
  end else begin : g_single
    assign rest_ok = cell_eq[0] | 1'b1;
  end

  assign hit = tail_ok & rest_ok;

endmodule

// ===== hdl/spt_out_buf.sv =====
module spt_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  spt_pkg::spt_result_t push_data,
  output logic                 push_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output spt_pkg::spt_result_t out_data
);
  import spt_pkg::*;

  logic        main_valid;
  logic        skid_valid;
  spt_result_t main_data;
  spt_result_t skid_data;
  logic        pop;

  assign push_ready = !skid_valid;
  assign out_valid  = main_valid;
  assign out_data   = main_data;
  assign pop        = main_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (push) begin
        main_data <= push_data;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

// ===== hdl/serial_phrase_trigger_responder.sv =====
// Channel  | Handshake            | Beat fields
// ---------+----------------------+-------------------------------------------
// input    | in_valid / in_ready  | rx_level, switch_level
// output   | out_valid / out_ready| tx_level, byte_done, rx_byte, phrase_hit
// config   | APB psel / penable   | paddr, pwdata, prdata (bit_ticks at 0x0)
//
// One beat is taken per clock while in_ready is high; its result is registered.
// The receive window is a row of byte cells that shift once per received byte.
// Reset (rst, synchronous) clears the window to zero bytes and bit_ticks to 104.
// A two-entry output buffer lets one more beat in while a result is stalled;
// in_ready falls only when both entries are full.
`include "serial_phrase_trigger_responder_macros.svh"

module serial_phrase_trigger_responder #(
  parameter int unsigned PHRASE_LEN = 45
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        rx_level,
  input  logic        switch_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        tx_level,
  output logic        byte_done,
  output logic [7:0]  rx_byte,
  output logic        phrase_hit,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import spt_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_CONFIRM,
    MODE_RECEIVE,
    MODE_SEND
  } mode_t;

  logic [15:0] bit_ticks;
  mode_t       mode, mode_next;
  logic [15:0] tick_count, tick_count_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [1:0]  reply_index, reply_index_next;
  logic        reply_long, reply_long_next;

  logic        step_en;
  logic        push;
  logic        win_hit;
  spt_result_t res;
  spt_result_t out_data;

  // Configuration port.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks <= BIT_TICKS_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_BIT_TICKS)) begin
      bit_ticks <= pwdata[15:0];
    end
  end
  assign prdata = (paddr[2] == REG_BIT_TICKS) ? {16'h0000, bit_ticks} : 32'h0;

  // Timing limits; zero values act as one tick.
  logic [16:0] period;
  logic [16:0] half;
  logic [16:0] tick_inc;
  logic [4:0]  bit_inc;
  logic [2:0]  tx_sel;
  logic [7:0]  reply_byte;

  assign period   = (bit_ticks == 16'd0) ? 17'd1 : {1'b0, bit_ticks};
  assign half     = (bit_ticks[15:1] == 15'd0) ? 17'd1 : {2'b00, bit_ticks[15:1]};
  assign tick_inc = {1'b0, tick_count} + 17'd1;
  assign bit_inc  = {1'b0, bit_count} + 5'd1;
  assign tx_sel   = bit_count[2:0] - 3'd1;
  assign reply_byte = (reply_long && (reply_index != 2'd3)) ? KEY_DOWN : KEY_ENTER;

  always_comb begin
    mode_next        = mode;
    tick_count_next  = tick_count;
    bit_count_next   = bit_count;
    shift_byte_next  = shift_byte;
    reply_index_next = reply_index;
    reply_long_next  = reply_long;
    push             = 1'b0;
    res.tx_level     = 1'b1;
    res.byte_done    = 1'b0;
    res.rx_byte      = 8'h00;
    res.phrase_hit   = 1'b0;
    unique case (mode)
      MODE_IDLE: begin
        if (!rx_level) begin
          mode_next       = MODE_CONFIRM;
          tick_count_next = 16'd0;
        end
      end
      MODE_CONFIRM: begin
        tick_count_next = tick_inc[15:0];
        if (tick_inc >= half) begin
          tick_count_next = 16'd0;
          bit_count_next  = 4'd0;
          mode_next       = rx_level ? MODE_IDLE : MODE_RECEIVE;
        end
      end
      MODE_RECEIVE: begin
        tick_count_next = tick_inc[15:0];
        if (tick_inc >= period) begin
          tick_count_next = 16'd0;
          if (bit_count < 4'd8) begin
            shift_byte_next = {rx_level, shift_byte[7:1]};
            bit_count_next  = bit_inc[3:0];
          end else begin
            bit_count_next = 4'd0;
            res.byte_done  = 1'b1;
            res.rx_byte    = shift_byte;
            push           = 1'b1;
            mode_next      = MODE_IDLE;
            if (win_hit) begin
              res.phrase_hit   = 1'b1;
              reply_long_next  = switch_level;
              reply_index_next = 2'd0;
              mode_next        = MODE_SEND;
            end
          end
        end
      end
      MODE_SEND: begin
        if (bit_count == 4'd0) begin
          res.tx_level = 1'b0;
        end else if (bit_count <= 4'd8) begin
          res.tx_level = reply_byte[tx_sel];
        end
        tick_count_next = tick_inc[15:0];
        if (tick_inc >= period) begin
          tick_count_next = 16'd0;
          bit_count_next  = bit_inc[3:0];
          if (bit_inc >= 5'd10) begin
            bit_count_next = 4'd0;
            if (!reply_long || (reply_index == 2'd3)) begin
              reply_index_next = 2'd0;
              mode_next        = MODE_IDLE;
            end else begin
              reply_index_next = reply_index + 2'd1;
            end
          end
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      tick_count  <= 16'd0;
      bit_count   <= 4'd0;
      shift_byte  <= 8'h00;
      reply_index <= 2'd0;
      reply_long  <= 1'b0;
    end else if (step_en) begin
      mode        <= mode_next;
      tick_count  <= tick_count_next;
      bit_count   <= bit_count_next;
      shift_byte  <= shift_byte_next;
      reply_index <= reply_index_next;
      reply_long  <= reply_long_next;
    end
  end

  assign step_en = in_valid && in_ready;

  spt_window #(
    .LEN (PHRASE_LEN)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .shift_en (step_en && push),
    .new_byte (shift_byte),
    .hit      (win_hit)
  );

  spt_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (step_en),
    .push_data  (res),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign tx_level   = out_data.tx_level;
  assign byte_done  = out_data.byte_done;
  assign rx_byte    = out_data.rx_byte;
  assign phrase_hit = out_data.phrase_hit;

  `SPT_ASSERT_NOW(a_hit_has_byte, step_en && res.phrase_hit, res.byte_done)
  `SPT_ASSERT_NOW(a_no_rx_in_send, step_en && (mode == MODE_SEND), !res.byte_done)
  `SPT_ASSERT_NEXT(a_hit_starts_send, step_en && res.phrase_hit, mode == MODE_SEND)

endmodule

// ===== sim/tb_serial_phrase_trigger_responder.sv =====
module tb_serial_phrase_trigger_responder;
  import spt_pkg::*;

  localparam int LINE_CHARS = 45;
  localparam logic [8*LINE_CHARS-1:0] TRIGGER_TEXT =
    "Use the ^ and v keys to change the selection.";

  localparam logic [2:0] ADDR_BIT_TICKS = 3'd0;
  localparam logic [2:0] ADDR_SPARE     = 3'd4;

  localparam spt_result_t IDLE_RES =
    '{tx_level: 1'b1, byte_done: 1'b0, rx_byte: 8'h00, phrase_hit: 1'b0};
  localparam spt_result_t ZERO_BYTE_RES =
    '{tx_level: 1'b1, byte_done: 1'b1, rx_byte: 8'h00, phrase_hit: 1'b0};
  localparam spt_result_t FULL_BYTE_RES =
    '{tx_level: 1'b1, byte_done: 1'b1, rx_byte: 8'hFF, phrase_hit: 1'b0};

  typedef enum logic [1:0] {RX_IDLE, RX_CONFIRM, RX_DATA, TX_REPLY} line_state_t;

  typedef struct {
    logic        rx;
    logic        sw;
    bit          has_want;
    spt_result_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        rx_level = 1'b1;
  logic        switch_level = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        tx_level;
  logic        byte_done;
  logic [7:0]  rx_byte;
  logic        phrase_hit;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Receiver and transmitter state as the testbench expects it to evolve.
  logic [15:0]  bit_len_cfg = BIT_TICKS_RESET;
  line_state_t  rcv_state = RX_IDLE;
  int unsigned  tick_ctr = 0;
  int unsigned  bit_ctr = 0;
  logic [7:0]   sr_byte = 8'h00;
  logic [7:0]   last_bytes [LINE_CHARS] = '{default: 8'h00};
  int unsigned  key_idx = 0;
  logic         keys_long = 1'b0;

  spt_result_t due_results [$];
  spt_result_t head_res;

  int src_gap_pct = 0;
  int sink_stall_pct = 0;
  int errors = 0;
  int items_sent = 0;
  int bytes_seen = 0;
  int hits_seen = 0;
  int tx_low_ticks = 0;

  // Bit period 1: the recheck lands one tick after the edge and each following
  // tick is a data sample, so the rows below are laid out on that timing.
  dir_row_t dir_rows [25] = '{
    '{1'b1, 1'b0, 1'b1, IDLE_RES},
    '{1'b0, 1'b1, 1'b0, IDLE_RES},
    '{1'b1, 1'b0, 1'b0, IDLE_RES},
    '{1'b0, 1'b0, 1'b0, IDLE_RES},
    '{1'b0, 1'b1, 1'b0, IDLE_RES},
    '{1'b0, 1'b0, 1'b0, IDLE_RES}, '{1'b0, 1'b1, 1'b0, IDLE_RES},
    '{1'b0, 1'b0, 1'b0, IDLE_RES}, '{1'b0, 1'b1, 1'b0, IDLE_RES},
    '{1'b0, 1'b0, 1'b0, IDLE_RES}, '{1'b0, 1'b1, 1'b0, IDLE_RES},
    '{1'b0, 1'b0, 1'b0, IDLE_RES}, '{1'b0, 1'b1, 1'b0, IDLE_RES},
    '{1'b1, 1'b1, 1'b1, ZERO_BYTE_RES},
    '{1'b0, 1'b0, 1'b0, IDLE_RES},
    '{1'b0, 1'b1, 1'b0, IDLE_RES},
    '{1'b1, 1'b0, 1'b0, IDLE_RES}, '{1'b1, 1'b1, 1'b0, IDLE_RES},
    '{1'b1, 1'b0, 1'b0, IDLE_RES}, '{1'b1, 1'b1, 1'b0, IDLE_RES},
    '{1'b1, 1'b0, 1'b0, IDLE_RES}, '{1'b1, 1'b1, 1'b0, IDLE_RES},
    '{1'b1, 1'b0, 1'b0, IDLE_RES}, '{1'b1, 1'b1, 1'b0, IDLE_RES},
    '{1'b1, 1'b0, 1'b1, FULL_BYTE_RES}
  };

  serial_phrase_trigger_responder #(.PHRASE_LEN(LINE_CHARS)) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_level     (rx_level),
    .switch_level (switch_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .tx_level     (tx_level),
    .byte_done    (byte_done),
    .rx_byte      (rx_byte),
    .phrase_hit   (phrase_hit),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  function automatic logic coin();
    return 1'($urandom_range(1));
  endfunction

  function automatic logic [7:0] trigger_char(input int idx);
    return TRIGGER_TEXT[8*(LINE_CHARS-1-idx) +: 8];
  endfunction

  function automatic int unsigned period_ticks();
    return (bit_len_cfg == 16'd0) ? 1 : bit_len_cfg;
  endfunction

  function automatic int unsigned half_ticks();
    return (bit_len_cfg[15:1] == 15'd0) ? 1 : bit_len_cfg[15:1];
  endfunction

  function automatic spt_result_t predict_tick(input logic rx, input logic sw);
    spt_result_t r;
    logic [7:0]  key;
    bit          match;
    r = IDLE_RES;
    case (rcv_state)
      RX_IDLE: begin
        if (!rx) begin
          rcv_state = RX_CONFIRM;
          tick_ctr = 0;
        end
      end
      RX_CONFIRM: begin
        tick_ctr++;
        if (tick_ctr >= half_ticks()) begin
          tick_ctr = 0;
          bit_ctr = 0;
          rcv_state = rx ? RX_IDLE : RX_DATA;
        end
      end
      RX_DATA: begin
        tick_ctr++;
        if (tick_ctr >= period_ticks()) begin
          tick_ctr = 0;
          if (bit_ctr < 8) begin
            sr_byte = {rx, sr_byte[7:1]};
            bit_ctr++;
          end else begin
            bit_ctr = 0;
            r.byte_done = 1'b1;
            r.rx_byte = sr_byte;
            rcv_state = RX_IDLE;
            for (int i = 0; i < LINE_CHARS - 1; i++) begin
              last_bytes[i] = last_bytes[i+1];
            end
            last_bytes[LINE_CHARS-1] = sr_byte;
            match = 1'b1;
            for (int i = 0; i < LINE_CHARS; i++) begin
              if (last_bytes[i] != trigger_char(i)) match = 1'b0;
            end
            if (match) begin
              r.phrase_hit = 1'b1;
              keys_long = sw;
              key_idx = 0;
              rcv_state = TX_REPLY;
            end
          end
        end
      end
      TX_REPLY: begin
        key = (keys_long && key_idx < 3) ? KEY_DOWN : KEY_ENTER;
        if (bit_ctr == 0) begin
          r.tx_level = 1'b0;
        end else if (bit_ctr <= 8) begin
          r.tx_level = key[bit_ctr-1];
        end
        tick_ctr++;
        if (tick_ctr >= period_ticks()) begin
          tick_ctr = 0;
          bit_ctr++;
          if (bit_ctr >= 10) begin
            bit_ctr = 0;
            if (!keys_long || key_idx >= 3) begin
              key_idx = 0;
              rcv_state = RX_IDLE;
            end else begin
              key_idx++;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic drive_tick(input logic rx, input logic sw, input bit has_want = 1'b0,
                            input spt_result_t want = IDLE_RES);
    spt_result_t res;
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_level <= rx;
    switch_level <= sw;
    do @(posedge clk); while (!in_ready);
    res = predict_tick(rx, sw);
    due_results.push_back(has_want ? want : res);
    items_sent++;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_bit_ticks_readback();
    logic [31:0] rd;
    apb_xfer(1'b0, ADDR_BIT_TICKS, 32'd0, rd);
    if (rd[15:0] !== bit_len_cfg) begin
      $error("bit_ticks readback: expected %0d, got %0d", bit_len_cfg, rd[15:0]);
      errors++;
    end
  endtask

  task automatic program_bit_ticks(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] unused_rd;
    apb_xfer(1'b1, addr, data, unused_rd);
    if (addr[2] == REG_BIT_TICKS) bit_len_cfg = data[15:0];
    check_bit_ticks_readback();
  endtask

  // One 8N1 frame laid out so that every sample point of the receiver falls
  // on the intended bit; the switch level is held at sw_end on the tick the
  // byte completes, which is when it gets latched.
  task automatic send_frame(input logic [7:0] b, input logic sw_end);
    int unsigned period;
    int unsigned half;
    int unsigned last;
    int unsigned k;
    logic        lvl;
    period = period_ticks();
    half = half_ticks();
    last = half + 9 * period;
    for (int unsigned o = 0; o <= last; o++) begin
      if (o <= half) begin
        lvl = 1'b0;
      end else begin
        k = (o - half - 1) / period;
        lvl = (k < 8) ? b[k] : 1'b1;
      end
      drive_tick(lvl, (o == last) ? sw_end : coin());
    end
    repeat ($urandom_range(1)) drive_tick(1'b1, coin());
  endtask

  // Sends the trigger text; bad_pos below zero leaves it intact, otherwise one
  // bit of that character is flipped.
  task automatic send_phrase(input int bad_pos, input logic sw_end);
    logic [7:0] b;
    while (rcv_state != RX_IDLE) drive_tick(1'b1, coin());
    for (int i = 0; i < LINE_CHARS; i++) begin
      b = trigger_char(i);
      if (i == bad_pos) b = b ^ (8'h01 << $urandom_range(7));
      send_frame(b, (i == LINE_CHARS - 1) ? sw_end : coin());
    end
  endtask

  task automatic random_traffic(input int segs);
    int unsigned pick;
    int unsigned cap;
    for (int s = 0; s < segs; s++) begin
      pick = $urandom_range(99);
      cap = (half_ticks() > 20) ? 20 : half_ticks();
      if (pick < 55) begin
        send_frame(8'($urandom_range(255)), coin());
      end else if (pick < 70) begin
        // A low pulse no longer than half a bit: the recheck sees it high.
        repeat ($urandom_range(cap, 1)) drive_tick(1'b0, coin());
        repeat (cap + 2) drive_tick(1'b1, coin());
      end else if (pick < 85) begin
        repeat ($urandom_range(12, 1)) drive_tick(coin(), coin());
      end else begin
        repeat ($urandom_range(40, 1)) drive_tick(1'b1, coin());
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (byte_done) bytes_seen++;
        if (phrase_hit) hits_seen++;
        if (!tx_level) tx_low_ticks++;
        if (due_results.size() == 0) begin
          $error("result beat arrived with nothing expected");
          errors++;
        end else begin
          head_res = due_results.pop_front();
          if (tx_level !== head_res.tx_level) begin
            $error("tx_level: expected %0b, got %0b", head_res.tx_level, tx_level);
            errors++;
          end
          if (byte_done !== head_res.byte_done) begin
            $error("byte_done: expected %0b, got %0b", head_res.byte_done, byte_done);
            errors++;
          end
          if (rx_byte !== head_res.rx_byte) begin
            $error("rx_byte: expected %02h, got %02h", head_res.rx_byte, rx_byte);
            errors++;
          end
          if (phrase_hit !== head_res.phrase_hit) begin
            $error("phrase_hit: expected %0b, got %0b", head_res.phrase_hit, phrase_hit);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_gap_pct = 17;
    sink_stall_pct = 51;
    check_bit_ticks_readback();
    program_bit_ticks(ADDR_BIT_TICKS, 32'd1);
    foreach (dir_rows[i]) begin
      drive_tick(dir_rows[i].rx, dir_rows[i].sw, dir_rows[i].has_want, dir_rows[i].want);
    end
    hold_until_drained();

    // Upper data bits must be dropped; the spare address must change nothing.
    program_bit_ticks(ADDR_BIT_TICKS, 32'hABCD_0002);
    program_bit_ticks(ADDR_SPARE, 32'h0000_0007);
    random_traffic(8);
    hold_until_drained();

    src_gap_pct = 51;
    sink_stall_pct = 17;
    program_bit_ticks(ADDR_BIT_TICKS, 32'd0);
    send_phrase(-1, 1'b1);
    // Idle line long enough for the whole four-byte reply to go out.
    repeat (45) drive_tick(1'b1, coin());
    random_traffic(3);
    // The sender stops here until every outstanding result beat is back.
    hold_until_drained();

    src_gap_pct = 0;
    sink_stall_pct = 0;
    program_bit_ticks(ADDR_BIT_TICKS, 32'hFFFF_FFFF);
    repeat (40) drive_tick($urandom_range(99) < 80, coin());
    hold_until_drained();
    program_bit_ticks(ADDR_BIT_TICKS, 32'd3);
    random_traffic(4);

    hold_until_drained();
    repeat (8) @(posedge clk);
    $display("%0d line ticks checked over bit periods 1, 2, 0, 65535 and 3 with idling mixes",
             items_sent);
    $display("%0d bytes decoded, %0d phrase matches, %0d ticks of reply line low",
             bytes_seen, hits_seen, tx_low_ticks);
    if (errors == 0) begin
      $display("[serial_phrase_trigger_responder] OK");
    end else begin
      $display("[serial_phrase_trigger_responder] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[serial_phrase_trigger_responder] ERROR");
    $finish;
  end

endmodule
